// ===== rtl/gradient_ramp_texel_generator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GRADIENT_RAMP_TEXEL_GENERATOR_ASSERT_SVH
`define GRADIENT_RAMP_TEXEL_GENERATOR_ASSERT_SVH

// Clocked assertion, muted while reset is asserted (active low).
`define GRTG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GRTG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/grtg_pkg.sv =====
`default_nettype none

package grtg_pkg;

    localparam int DEF_RAMP_LENGTH = 64;
    localparam int DEF_ROW_COUNT   = 256;

    localparam int OFFSET_W   = 17;
    localparam int COLOR_W    = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int ROW_OUT_W  = 8;
    localparam int IDX_OUT_W  = 6;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;
    localparam int DIV_CNT_W  = $clog2(CH_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PAD_LO,
        ST_DIV,
        ST_INTERP,
        ST_TAIL,
        ST_PAD_HI
    } state_t;

    typedef struct packed {
        logic load;
        logic set_j_zero;
        logic set_j_pos;
        logic div_start;
        logic div_step;
        logic emit;
        logic emit_interp;
        logic run_end;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_gradient;
        logic last;
        logic pos_gt_prev;
        logic pos_full;
        logic j_at_pos;
        logic j_at_end;
        logic j_last_seg;
        logic j_last_row;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/grtg_datapath.sv =====
`default_nettype none

module grtg_datapath #(
    parameter int RAMP_LENGTH = grtg_pkg::DEF_RAMP_LENGTH,
    parameter int ROW_COUNT   = grtg_pkg::DEF_ROW_COUNT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [grtg_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    input  wire grtg_pkg::ctrl_cmd_t            cmd,
    output grtg_pkg::ctrl_status_t              status,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [grtg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                                m_tlast
);
    import grtg_pkg::*;

    localparam int PW    = $clog2(RAMP_LENGTH + 1);
    localparam int RW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int PRODW = OFFSET_W + PW + 1;
    localparam int QW    = CH_W + 2;

    // Stop registers and gradient state
    logic [PW-1:0]      pos_reg, prev_pos_reg, j_reg, len_reg;
    logic [COLOR_W-1:0] color_reg, prev_color_reg;
    logic               last_reg, inside_reg;
    logic [RW-1:0]      row_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Per-channel divider and interpolation accumulators
    logic [CH_W-1:0] dvd_reg   [NUM_CH];
    logic [PW-1:0]   rem_reg   [NUM_CH];
    logic [CH_W-1:0] quo_reg   [NUM_CH];
    logic            neg_reg   [NUM_CH];
    logic [CH_W-1:0] acc_q_reg [NUM_CH];
    logic [PW-1:0]   acc_r_reg [NUM_CH];

    logic [PW-1:0]   rem_next   [NUM_CH];
    logic            quo_bit    [NUM_CH];
    logic [CH_W-1:0] acc_q_next [NUM_CH];
    logic [PW-1:0]   acc_r_next [NUM_CH];
    logic [CH_W-1:0] start_ch   [NUM_CH];
    logic [CH_W-1:0] end_ch     [NUM_CH];

    logic               m_valid_reg, m_last_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [OFFSET_W-1:0] s_offset;
    logic [COLOR_W-1:0]  s_color;
    logic [PRODW-1:0]    prod;
    logic [PW+1:0]       pos_raw;
    logic [PW-1:0]       pos_in;
    logic [COLOR_W-1:0]  interp_color;
    logic [COLOR_W-1:0]  texel_color;

    assign s_offset = s_tdata[OFFSET_W-1:0];
    assign s_color  = s_tdata[OFFSET_W +: COLOR_W];

    // floor(offset * RAMP_LENGTH + 0.5), saturated at RAMP_LENGTH
    assign prod    = PRODW'(s_offset) * PRODW'(RAMP_LENGTH) + PRODW'(32768);
    assign pos_raw = prod[PRODW-1:16];
    assign pos_in  = (pos_raw > (PW+2)'(RAMP_LENGTH)) ? PW'(RAMP_LENGTH) : PW'(pos_raw);

    always_comb begin
        logic [PW:0]   shifted;
        logic [PW:0]   rsum;
        logic [PW-1:0] rd;
        logic [QW-1:0] qd;
        logic [QW-1:0] qsum;
        logic          wrap;
        for (int c = 0; c < NUM_CH; c++) begin
            start_ch[c] = prev_color_reg[c*CH_W +: CH_W];
            end_ch[c]   = color_reg[c*CH_W +: CH_W];

            // One restoring-division step of |e - s| by the segment length
            shifted     = {rem_reg[c], dvd_reg[c][CH_W-1]};
            quo_bit[c]  = (shifted >= {1'b0, len_reg});
            rem_next[c] = quo_bit[c] ? PW'(shifted - {1'b0, len_reg}) : PW'(shifted);

            // Floor quotient and remainder of the signed step
            if (neg_reg[c] && (rem_reg[c] != '0)) begin
                qd = QW'(0) - QW'(quo_reg[c]) - QW'(1);
                rd = len_reg - rem_reg[c];
            end else if (neg_reg[c]) begin
                qd = QW'(0) - QW'(quo_reg[c]);
                rd = rem_reg[c];
            end else begin
                qd = QW'(quo_reg[c]);
                rd = rem_reg[c];
            end

            // Advance the running quotient/remainder by one texel
            rsum          = {1'b0, acc_r_reg[c]} + {1'b0, rd};
            wrap          = (rsum >= {1'b0, len_reg});
            acc_r_next[c] = wrap ? PW'(rsum - {1'b0, len_reg}) : PW'(rsum);
            qsum          = QW'(acc_q_reg[c]) + qd + QW'(wrap);
            acc_q_next[c] = qsum[CH_W-1:0];

            interp_color[c*CH_W +: CH_W] = acc_q_reg[c];
        end
    end

    assign texel_color = cmd.emit_interp ? interp_color : color_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg   <= pos_in;
            color_reg <= s_color;
            last_reg  <= s_tlast;
        end

        if (cmd.set_j_zero) begin
            j_reg <= '0;
        end else if (cmd.set_j_pos) begin
            j_reg <= pos_reg;
        end else if (cmd.div_start) begin
            j_reg <= prev_pos_reg;
        end else if (cmd.emit) begin
            j_reg <= j_reg + PW'(1);
        end

        if (cmd.div_start) begin
            len_reg     <= pos_reg - prev_pos_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end

        for (int c = 0; c < NUM_CH; c++) begin
            if (cmd.div_start) begin
                neg_reg[c]   <= (end_ch[c] < start_ch[c]);
                dvd_reg[c]   <= (end_ch[c] < start_ch[c]) ? start_ch[c] - end_ch[c]
                                                          : end_ch[c] - start_ch[c];
                rem_reg[c]   <= '0;
                quo_reg[c]   <= '0;
                acc_q_reg[c] <= start_ch[c];
                acc_r_reg[c] <= '0;
            end else if (cmd.div_step) begin
                dvd_reg[c] <= {dvd_reg[c][CH_W-2:0], 1'b0};
                rem_reg[c] <= rem_next[c];
                quo_reg[c] <= {quo_reg[c][CH_W-2:0], quo_bit[c]};
            end else if (cmd.emit && cmd.emit_interp) begin
                acc_q_reg[c] <= acc_q_next[c];
                acc_r_reg[c] <= acc_r_next[c];
            end
        end

        if (cmd.emit) begin
            m_data_reg <= M_TDATA_W'({texel_color, IDX_OUT_W'(j_reg), ROW_OUT_W'(row_reg)});
            m_last_reg <= cmd.run_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg     <= 1'b0;
            prev_pos_reg   <= '0;
            prev_color_reg <= '0;
            row_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.finish) begin
                if (last_reg) begin
                    inside_reg     <= 1'b0;
                    prev_pos_reg   <= '0;
                    prev_color_reg <= '0;
                    row_reg        <= (row_reg == RW'(ROW_COUNT - 1)) ? '0 : row_reg + RW'(1);
                end else begin
                    inside_reg     <= 1'b1;
                    prev_pos_reg   <= pos_reg;
                    prev_color_reg <= color_reg;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.in_gradient = inside_reg;
        status.last        = last_reg;
        status.pos_gt_prev = (pos_reg > prev_pos_reg);
        status.pos_full    = (pos_reg == PW'(RAMP_LENGTH));
        status.j_at_pos    = (j_reg == pos_reg);
        status.j_at_end    = (j_reg == PW'(RAMP_LENGTH));
        status.j_last_seg  = ((j_reg + PW'(1)) == pos_reg);
        status.j_last_row  = (j_reg == PW'(RAMP_LENGTH - 1));
        status.div_done    = (div_cnt_reg == DIV_CNT_W'(CH_W - 1));
        status.out_free    = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/grtg_ctrl.sv =====
`default_nettype none

module grtg_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire grtg_pkg::ctrl_status_t status,
    output grtg_pkg::ctrl_cmd_t         cmd
);
    import grtg_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!status.in_gradient) begin
                    cmd.set_j_zero = 1'b1;
                    state_next     = ST_PAD_LO;
                end else if (status.pos_gt_prev) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_PAD_LO: begin
                if (status.j_at_pos) begin
                    state_next = ST_TAIL;
                end else if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.run_end = status.j_last_seg && (!status.last || status.pos_full);
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP: begin
                if (status.j_at_pos) begin
                    state_next = ST_TAIL;
                end else if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_interp = 1'b1;
                    cmd.run_end     = status.j_last_seg && (!status.last || status.pos_full);
                end
            end
            ST_TAIL: begin
                if (status.last) begin
                    cmd.set_j_pos = 1'b1;
                    state_next    = ST_PAD_HI;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PAD_HI: begin
                if (status.j_at_end) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.run_end = status.j_last_row;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gradient_ramp_texel_generator.sv =====
`default_nettype none

// Gradient ramp texel generator: feed the color stops of one gradient in
// order (offset in Q1.16, packed RGBA color, tlast on the final stop) and the
// block streams out the RAMP_LENGTH-texel row of that gradient with pad
// spread, one texel per cycle in ascending order while the output is not
// stalled, tlast marking the last texel a stop produced. Stops are taken
// one at a time. Each stop passes through accept, decide and close steps
// and through each pad or blend phase it enters; a first stop always
// enters the leading pad, a final stop the trailing pad, and a stop that
// blends from the previous one also passes through the per-channel step
// divider (one quotient bit per cycle). A stop placed at or before the
// previous one enters no leading phase. Rows are numbered modulo ROW_COUNT.
module gradient_ramp_texel_generator #(
    parameter int RAMP_LENGTH = grtg_pkg::DEF_RAMP_LENGTH,
    parameter int ROW_COUNT   = grtg_pkg::DEF_ROW_COUNT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // stop_offset[16:0], stop_color[48:17], zero fill[55:49]
    input  wire logic [grtg_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // ramp_row[7:0], texel_index[13:8], red[21:14], green[29:22], blue[37:30],
    // alpha[45:38], zero fill[47:46]
    output logic      [grtg_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tlast
);
    import grtg_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    grtg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grtg_datapath #(
        .RAMP_LENGTH (RAMP_LENGTH),
        .ROW_COUNT   (ROW_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/grtg_checker.sv =====
`default_nettype none

`include "gradient_ramp_texel_generator_assert.svh"

module grtg_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [grtg_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                           s_axis_tlast,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [grtg_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    // A stalled texel holds its payload.
    `GRTG_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled texel changed")

    // Each stop keeps the input closed for at least the cycle after it is taken.
    `GRTG_ASSERT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input ready right after a stop was taken")

    // More texels of the current stop remain, so no new stop may enter.
    `GRTG_ASSERT(a_busy_mid_run, aclk, aresetn, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready, "input ready in the middle of a texel run")

    // Reset empties the output register.
    `GRTG_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_axis_tvalid, "texel valid after reset")

endmodule

bind gradient_ramp_texel_generator grtg_checker u_grtg_checker (.*);

`default_nettype wire

// ===== test/tb_gradient_ramp_texel_generator.sv =====
`timescale 1ns / 100ps

module tb_gradient_ramp_texel_generator;

    import grtg_pkg::*;

    localparam int RAMP_LEN     = 64;
    localparam int OFFSET_ONE   = 65536;
    localparam int ITEM_TARGET  = 470;
    localparam int ROW_TARGET   = 260;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_TICKS = 100;

    typedef struct packed {
        logic [7:0] row;
        logic [5:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       run_end;
    } ramp_texel_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // Predictor state of the ramp generator.
    int          prev_pos;
    logic [31:0] prev_color;
    logic        in_gradient;
    logic [7:0]  row_cnt;

    ramp_texel_t pending_texels[$];
    int          n_items;
    int          n_texels;
    int          n_rows;
    int          n_bad;
    bit          idle_on;
    int          rx_stall;

    gradient_ramp_texel_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("timeout with %0d texels outstanding", pending_texels.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_color();
        logic [31:0] c;
        int          r;
        for (int ch = 0; ch < 4; ch++) begin
            r = $urandom_range(0, 99);
            if (r < 15) c[8*ch +: 8] = 8'h00;
            else if (r < 30) c[8*ch +: 8] = 8'hFF;
            else c[8*ch +: 8] = 8'($urandom);
        end
        return c;
    endfunction

    function automatic logic [31:0] blend_color(logic [31:0] s, logic [31:0] e, int k, int len);
        logic [31:0] c;
        int          sc;
        int          ec;
        for (int ch = 0; ch < 4; ch++) begin
            sc = int'(s[8*ch +: 8]);
            ec = int'(e[8*ch +: 8]);
            c[8*ch +: 8] = 8'((sc * (len - k) + ec * k) / len);
        end
        return c;
    endfunction

    function automatic void push_texel(int idx, logic [31:0] c);
        ramp_texel_t t;
        t.row     = row_cnt;
        t.idx     = 6'(idx);
        t.red     = c[7:0];
        t.green   = c[15:8];
        t.blue    = c[23:16];
        t.alpha   = c[31:24];
        t.run_end = 1'b0;
        pending_texels = {pending_texels, t};
    endfunction

    // Queue the texels one accepted stop produces, then advance the state.
    function automatic void ramp_texels_for_stop(logic [16:0] off, logic [31:0] c, logic last);
        int pos;
        int len;
        int n_before;
        pos = (int'(off) * RAMP_LEN + 32768) >>> 16;
        if (pos > RAMP_LEN) pos = RAMP_LEN;
        n_before = pending_texels.size();
        if (!in_gradient) begin
            for (int j = 0; j < pos; j++) push_texel(j, c);
        end else if (pos > prev_pos) begin
            len = pos - prev_pos;
            for (int j = prev_pos; j < pos; j++)
                push_texel(j, blend_color(prev_color, c, j - prev_pos, len));
        end
        if (last) begin
            for (int j = pos; j < RAMP_LEN; j++) push_texel(j, c);
        end
        if (pending_texels.size() > n_before)
            pending_texels[pending_texels.size() - 1].run_end = 1'b1;
        if (last) begin
            in_gradient = 1'b0;
            prev_pos    = 0;
            prev_color  = '0;
            row_cnt     = row_cnt + 8'd1;
            n_rows++;
        end else begin
            in_gradient = 1'b1;
            prev_pos    = pos;
            prev_color  = c;
        end
    endfunction

    function automatic void report_texel(string what, ramp_texel_t want, ramp_texel_t got);
        n_bad++;
        if (n_bad <= REPORT_LIMIT) begin
            $display("%0t %s: expected row %0d idx %0d rgba %h %h %h %h end %b,",
                     $time, what, want.row, want.idx, want.red, want.green, want.blue,
                     want.alpha, want.run_end);
            $display("    got row %0d idx %0d rgba %h %h %h %h end %b",
                     got.row, got.idx, got.red, got.green, got.blue, got.alpha,
                     got.run_end);
        end
    endfunction

    function automatic void check_texel(logic [M_TDATA_W-1:0] d, logic tl);
        ramp_texel_t want;
        ramp_texel_t got;
        got.row     = d[7:0];
        got.idx     = d[13:8];
        got.red     = d[21:14];
        got.green   = d[29:22];
        got.blue    = d[37:30];
        got.alpha   = d[45:38];
        got.run_end = tl;
        n_texels++;
        if (pending_texels.size() == 0) begin
            report_texel("unexpected texel", '0, got);
            return;
        end
        want = pending_texels.pop_front();
        if (got.row !== want.row || got.idx !== want.idx || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.run_end !== want.run_end)
            report_texel("texel mismatch", want, got);
    endfunction

    // Check each accepted texel and stall the result side at random.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            check_texel(m_axis_tdata, m_axis_tlast);
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall = pick_gap();
            m_axis_tready <= (rx_stall == 0);
        end
    end

    task automatic send_stop(input logic [16:0] off, input logic [31:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, c, off};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        ramp_texels_for_stop(off, c, last);
        n_items++;
    endtask

    // Hold the next stop until every queued texel has come out.
    task automatic drain_texels();
        s_axis_tvalid <= 1'b0;
        while (pending_texels.size() != 0) @(posedge aclk);
    endtask

    task automatic test_single_stop_rows();
        send_stop(17'd0, 32'h0000_0000, 1'b1);
        send_stop(17'h10000, 32'hFFFF_FFFF, 1'b1);
        // offset above 1.0 saturates at the row end
        send_stop(17'h1FFFF, pick_color(), 1'b1);
        drain_texels();
    endtask

    task automatic test_three_stop_blend();
        send_stop(17'd0, 32'h0000_0000, 1'b0);
        send_stop(17'h4000, 32'hFFFF_FFFF, 1'b0);
        send_stop(17'h8000, 32'h00FF_00FF, 1'b0);
        send_stop(17'h10000, 32'h8040_20FF, 1'b1);
        drain_texels();
    endtask

    task automatic test_decreasing_offsets();
        send_stop(17'hC000, pick_color(), 1'b0);
        send_stop(17'h4000, pick_color(), 1'b0);
        send_stop(17'h8000, pick_color(), 1'b1);
        drain_texels();
    endtask

    task automatic test_empty_segments();
        send_stop(17'd0, pick_color(), 1'b0);
        send_stop(17'h6000, pick_color(), 1'b0);
        send_stop(17'h6000, pick_color(), 1'b0);
        send_stop(17'h6000, pick_color(), 1'b1);
        // last stop past 1.0 leaves no tail to pad
        send_stop(17'h4000, pick_color(), 1'b0);
        send_stop(17'h18000, pick_color(), 1'b1);
        drain_texels();
    endtask

    task automatic test_position_rounding();
        send_stop(17'd511, pick_color(), 1'b0);
        send_stop(17'd512, pick_color(), 1'b0);
        send_stop(17'd1535, pick_color(), 1'b0);
        send_stop(17'd1536, pick_color(), 1'b0);
        send_stop(17'd65503, pick_color(), 1'b1);
        drain_texels();
    endtask

    // Mostly ordered gradients with random stops, many of them single-stop
    // rows; some stray stops and out-of-order offsets. Run on until the row
    // counter has wrapped.
    task automatic test_random_gradients();
        int          n_stops;
        int          cur;
        int          r;
        logic [16:0] off;
        while (n_items < ITEM_TARGET || n_rows < ROW_TARGET) begin
            if ($urandom_range(0, 99) < 10) begin
                send_stop(17'($urandom_range(0, 17'h1FFFF)), 32'($urandom),
                          1'($urandom_range(0, 1)));
            end else begin
                n_stops = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, 5);
                cur = 0;
                for (int k = 0; k < n_stops; k++) begin
                    r = $urandom_range(0, 99);
                    if (k > 0 && r < 8)
                        cur = cur;
                    else if (k > 0 && r < 14)
                        cur = $urandom_range(0, cur);
                    else
                        cur = cur + $urandom_range(0, (OFFSET_ONE - cur) / (n_stops - k));
                    if (k == n_stops - 1 && r >= 92)
                        cur = (r >= 96) ? $urandom_range(OFFSET_ONE, 17'h1FFFF) : OFFSET_ONE;
                    off = 17'(cur);
                    send_stop(off, pick_color(), k == n_stops - 1);
                end
            end
            if ($urandom_range(0, 49) == 0) drain_texels();
            if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        end
    endtask

    initial begin
        prev_pos      = 0;
        prev_color    = '0;
        in_gradient   = 1'b0;
        row_cnt       = '0;
        n_items       = 0;
        n_texels      = 0;
        n_rows        = 0;
        n_bad         = 0;
        rx_stall      = 0;
        idle_on       = 1'b1;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_stop_rows();
        test_three_stop_blend();
        test_decreasing_offsets();
        test_empty_segments();
        test_position_rounding();
        test_random_gradients();

        drain_texels();
        repeat (SETTLE_TICKS) @(posedge aclk);
        $display("Sent %0d stops over %0d rows (row counter wrapped), checked %0d texels",
                 n_items, n_rows, n_texels);
        $display("with random gaps and stalls on both channels; %0d bad texels, %0d left over",
                 n_bad, pending_texels.size());
        if (n_bad == 0 && pending_texels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
